@@ src/blh_pkg.sv @@
// types and constants shared by the bond length histogram unit
// no dependencies
`default_nettype none

package blh_pkg;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_BOND = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_NOP  = 2'd3;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic CSR_BIN_WIDTH   = 1'b0;
   localparam logic CSR_BINS_IN_USE = 1'b1;

   localparam int COORD_W    = 32;
   localparam int DIFF_W     = 33;
   localparam int SQ_W       = 66;
   localparam int RAD_W      = 68;
   localparam int ROOT_W     = 34;
   localparam int REM_W      = 38;
   localparam int ITER_W     = 6;
   localparam logic [ITER_W-1:0] ITER_FIRST = 6'd33;
   localparam int WIDE_W     = 17;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_RD_A, ST_RD_B, ST_SQ_X, ST_SQ_Y, ST_SQ_Z,
      ST_SQ_SUM, ST_SQRT_INIT, ST_SQRT, ST_DIV_INIT, ST_DIV, ST_CHECK, ST_BIN_RD,
      ST_BIN_WR, ST_CNT_RD, ST_CNT_WAIT, ST_FINISH
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       clear_step;
      logic       load_wr;
      logic       rd_a;
      logic       rd_b;
      logic       sq_en;
      logic [1:0] sq_axis;
      logic       acc_en;
      logic       acc_first;
      logic       sqrt_init;
      logic       div_init;
      logic       iter_en;
      logic       check;
      logic       bin_rd;
      logic       bin_wr;
      logic       cnt_rd;
      logic       cnt_set;
      logic       push;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic iter_last;
      logic bond_ok;
   } dp_status_type;

endpackage

`default_nettype wire

@@ src/bond_length_histogram_unit.sv @@
// top level of the bond length histogram unit: ports, configuration registers
// uses blh_pkg, blh_ctrl and blh_datapath
`default_nettype none

// Histogram of distances between stored atoms. After reset a clearing pass
// zeroes the bin counts; no item is taken until it ends. One item is worked
// at a time and each gives one result. A bond takes two reads of the
// single-port coordinate memory, three squares on one multiplier, then
// 34 steps of the shared iterative unit for the square root and 34 more for
// the division by the bin width, and, if the length falls in a bin in use,
// a read-modify-write of the bin memory.
module bond_length_histogram_unit #(
   parameter int ATOM_SLOTS = 4096,
   parameter int MAX_BINS   = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // first_atom, second_atom, pos_x, pos_y, pos_z, read_bin
   input  wire logic [135:0] req_tdata,
   // command
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // bin_hit, bond_length, bin_count
   output logic [79:0]       rsp_tdata,
   // status
   output logic [0:0]        rsp_tuser,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [31:0] bin_width_ff;
   logic [10:0] bins_in_use_ff;
   blh_pkg::ctl_cmd_type   cmd;
   blh_pkg::dp_status_type status;
   logic        rsp_status;
   logic [9:0]  rsp_bin_hit;
   logic [33:0] rsp_bond_length;
   logic [31:0] rsp_bin_count;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff   <= 32'd6554;
         bins_in_use_ff <= 11'd1024;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            blh_pkg::CSR_BIN_WIDTH:   bin_width_ff   <= csr_pwdata;
            blh_pkg::CSR_BINS_IN_USE: bins_in_use_ff <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         blh_pkg::CSR_BINS_IN_USE: csr_prdata = 32'(bins_in_use_ff);
         default:                  csr_prdata = bin_width_ff;
      endcase
   end

   blh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tuser),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .cmd         (cmd)
   );

   blh_datapath #(
      .ATOM_SLOTS (ATOM_SLOTS),
      .MAX_BINS   (MAX_BINS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .first_atom      (req_tdata[11:0]),
      .second_atom     (req_tdata[23:12]),
      .pos_x           (req_tdata[55:24]),
      .pos_y           (req_tdata[87:56]),
      .pos_z           (req_tdata[119:88]),
      .read_bin        (req_tdata[129:120]),
      .bin_width       (bin_width_ff),
      .bins_in_use     (bins_in_use_ff),
      .rsp_status      (rsp_status),
      .rsp_bin_hit     (rsp_bin_hit),
      .rsp_bond_length (rsp_bond_length),
      .rsp_bin_count   (rsp_bin_count)
   );

   assign rsp_tdata = {4'b0, rsp_bin_count, rsp_bond_length, rsp_bin_hit};
   assign rsp_tuser = rsp_status;

endmodule

`default_nettype wire

@@ src/blh_ctrl.sv @@
// controller state machine of the bond length histogram unit
// uses blh_pkg; drives the datapath by command struct
`default_nettype none

module blh_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic [1:0]             req_command,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire blh_pkg::dp_status_type status,
   output blh_pkg::ctl_cmd_type        cmd
);

   blh_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blh_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         blh_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = blh_pkg::ST_IDLE;
         end
         blh_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               case (req_command)
                  blh_pkg::CMD_LOAD: state_in = blh_pkg::ST_LOAD;
                  blh_pkg::CMD_BOND: state_in = blh_pkg::ST_RD_A;
                  blh_pkg::CMD_READ: state_in = blh_pkg::ST_CNT_RD;
                  default:           state_in = blh_pkg::ST_FINISH;
               endcase
            end
         end
         blh_pkg::ST_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = blh_pkg::ST_FINISH;
         end
         blh_pkg::ST_RD_A: begin
            cmd.rd_a = 1'b1;
            state_in = blh_pkg::ST_RD_B;
         end
         blh_pkg::ST_RD_B: begin
            cmd.rd_b = 1'b1;
            state_in = blh_pkg::ST_SQ_X;
         end
         blh_pkg::ST_SQ_X: begin
            cmd.sq_en   = 1'b1;
            cmd.sq_axis = blh_pkg::AXIS_X;
            state_in    = blh_pkg::ST_SQ_Y;
         end
         blh_pkg::ST_SQ_Y: begin
            cmd.sq_en     = 1'b1;
            cmd.sq_axis   = blh_pkg::AXIS_Y;
            cmd.acc_en    = 1'b1;
            cmd.acc_first = 1'b1;
            state_in      = blh_pkg::ST_SQ_Z;
         end
         blh_pkg::ST_SQ_Z: begin
            cmd.sq_en   = 1'b1;
            cmd.sq_axis = blh_pkg::AXIS_Z;
            cmd.acc_en  = 1'b1;
            state_in    = blh_pkg::ST_SQ_SUM;
         end
         blh_pkg::ST_SQ_SUM: begin
            cmd.acc_en = 1'b1;
            state_in   = blh_pkg::ST_SQRT_INIT;
         end
         blh_pkg::ST_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            state_in      = blh_pkg::ST_SQRT;
         end
         blh_pkg::ST_SQRT: begin
            cmd.iter_en = 1'b1;
            if (status.iter_last) state_in = blh_pkg::ST_DIV_INIT;
         end
         blh_pkg::ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = blh_pkg::ST_DIV;
         end
         blh_pkg::ST_DIV: begin
            cmd.iter_en = 1'b1;
            if (status.iter_last) state_in = blh_pkg::ST_CHECK;
         end
         blh_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.bond_ok ? blh_pkg::ST_BIN_RD : blh_pkg::ST_FINISH;
         end
         blh_pkg::ST_BIN_RD: begin
            cmd.bin_rd = 1'b1;
            state_in   = blh_pkg::ST_BIN_WR;
         end
         blh_pkg::ST_BIN_WR: begin
            cmd.bin_wr = 1'b1;
            state_in   = blh_pkg::ST_FINISH;
         end
         blh_pkg::ST_CNT_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = blh_pkg::ST_CNT_WAIT;
         end
         blh_pkg::ST_CNT_WAIT: begin
            cmd.cnt_set = 1'b1;
            state_in    = blh_pkg::ST_FINISH;
         end
         blh_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.push = 1'b1;
               state_in = blh_pkg::ST_IDLE;
            end
         end
         default: state_in = blh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.push) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == blh_pkg::ST_CLEAR) |-> !req_tready)
      else $error("item taken during clearing pass");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != blh_pkg::ST_IDLE))
      else $error("controller stayed idle after item");
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before taken");
   a_sqrt_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == blh_pkg::ST_SQRT && status.iter_last) |=>
      (state_ff == blh_pkg::ST_DIV_INIT))
      else $error("square root did not hand over to divide");
`endif

endmodule

`default_nettype wire

@@ src/blh_datapath.sv @@
// datapath: coordinate memory, squares, shared square root and divide unit, bin memory
// uses blh_pkg; commanded by blh_ctrl
`default_nettype none

module blh_datapath #(
   parameter int ATOM_SLOTS = 4096,
   parameter int MAX_BINS   = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire blh_pkg::ctl_cmd_type   cmd,
   output blh_pkg::dp_status_type      status,
   input  wire logic [11:0]            first_atom,
   input  wire logic [11:0]            second_atom,
   input  wire logic [31:0]            pos_x,
   input  wire logic [31:0]            pos_y,
   input  wire logic [31:0]            pos_z,
   input  wire logic [9:0]             read_bin,
   input  wire logic [31:0]            bin_width,
   input  wire logic [10:0]            bins_in_use,
   output logic                        rsp_status,
   output logic [9:0]                  rsp_bin_hit,
   output logic [33:0]                 rsp_bond_length,
   output logic [31:0]                 rsp_bin_count
);

   localparam int ATOM_AW = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;
   localparam int BIN_AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CW      = blh_pkg::COORD_W;

   logic [3*CW-1:0] coord_mem [ATOM_SLOTS];
   logic [31:0]     bin_mem [MAX_BINS];

   logic [11:0]     a1_ff, a2_ff;
   logic [3*CW-1:0] pos_ff;
   logic [9:0]      rb_ff;
   logic            a1_ok_ff, a2_ok_ff, rb_ok_ff;
   logic [3*CW-1:0] coord_rd_ff, atom_a_ff;
   logic [blh_pkg::SQ_W-1:0] prod_ff, sum_ff;
   logic [blh_pkg::RAD_W-1:0] rad_ff;
   logic [blh_pkg::REM_W-1:0] rem_ff;
   logic [blh_pkg::ROOT_W-1:0] root_ff;
   logic [blh_pkg::ITER_W-1:0] iter_ff;
   logic            mode_sqrt_ff;
   logic [BIN_AW-1:0] clr_cnt_ff;
   logic [31:0]     bin_rd_ff;
   logic            res_status_ff;
   logic [9:0]      res_hit_ff;
   logic [33:0]     res_len_ff;
   logic [31:0]     res_count_ff;

   logic [blh_pkg::WIDE_W-1:0] a1_wide, a2_wide, rb_wide, in_a1_wide, in_a2_wide, in_rb_wide;
   logic [ATOM_AW-1:0] a1_addr, a2_addr;
   logic [3*CW-1:0] atom_a, atom_b;
   logic [CW-1:0]   ca, cb;
   logic signed [blh_pkg::DIFF_W-1:0] diff;
   logic [blh_pkg::DIFF_W-1:0] mag;
   logic [blh_pkg::REM_W-1:0] shifted, trial, rem_sub;
   logic            ge;
   logic [blh_pkg::WIDE_W-1:0] lim;
   logic [BIN_AW-1:0] q_addr;

   always_comb begin
      in_a1_wide = blh_pkg::WIDE_W'(first_atom);
      in_a2_wide = blh_pkg::WIDE_W'(second_atom);
      in_rb_wide = blh_pkg::WIDE_W'(read_bin);
      a1_wide    = blh_pkg::WIDE_W'(a1_ff);
      a2_wide    = blh_pkg::WIDE_W'(a2_ff);
      rb_wide    = blh_pkg::WIDE_W'(rb_ff);
      a1_addr    = a1_wide[ATOM_AW-1:0];
      a2_addr    = a2_wide[ATOM_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         a1_ff    <= first_atom;
         a2_ff    <= second_atom;
         pos_ff   <= {pos_z, pos_y, pos_x};
         rb_ff    <= read_bin;
         a1_ok_ff <= in_a1_wide < blh_pkg::WIDE_W'(ATOM_SLOTS);
         a2_ok_ff <= in_a2_wide < blh_pkg::WIDE_W'(ATOM_SLOTS);
         rb_ok_ff <= in_rb_wide < blh_pkg::WIDE_W'(MAX_BINS);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && a1_ok_ff) coord_mem[a1_addr] <= pos_ff;
      if (cmd.rd_a) coord_rd_ff <= coord_mem[a1_addr];
      else if (cmd.rd_b) coord_rd_ff <= coord_mem[a2_addr];
      if (cmd.rd_b) atom_a_ff <= coord_rd_ff;
   end

   always_comb begin
      atom_a = a1_ok_ff ? atom_a_ff : '0;
      atom_b = a2_ok_ff ? coord_rd_ff : '0;
      case (cmd.sq_axis)
         blh_pkg::AXIS_Y: begin ca = atom_a[2*CW-1:CW];   cb = atom_b[2*CW-1:CW];   end
         blh_pkg::AXIS_Z: begin ca = atom_a[3*CW-1:2*CW]; cb = atom_b[3*CW-1:2*CW]; end
         default:         begin ca = atom_a[CW-1:0];      cb = atom_b[CW-1:0];      end
      endcase
      diff = $signed({ca[CW-1], ca}) - $signed({cb[CW-1], cb});
      mag  = diff[blh_pkg::DIFF_W-1] ? blh_pkg::DIFF_W'(-diff) : blh_pkg::DIFF_W'(diff);
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_en) prod_ff <= mag * mag;
      if (cmd.acc_en) sum_ff <= (cmd.acc_first ? '0 : sum_ff) + prod_ff;
   end

   always_comb begin
      if (mode_sqrt_ff) begin
         shifted = {rem_ff[blh_pkg::REM_W-3:0], rad_ff[blh_pkg::RAD_W-1 -: 2]};
         trial   = blh_pkg::REM_W'({root_ff, 2'b01});
      end else begin
         shifted = {rem_ff[blh_pkg::REM_W-2:0], rad_ff[blh_pkg::RAD_W-1]};
         trial   = blh_pkg::REM_W'(bin_width);
      end
      ge      = shifted >= trial;
      rem_sub = ge ? shifted - trial : shifted;
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         mode_sqrt_ff <= 1'b1;
         rad_ff       <= blh_pkg::RAD_W'(sum_ff);
         rem_ff       <= '0;
         root_ff      <= '0;
         iter_ff      <= blh_pkg::ITER_FIRST;
      end else if (cmd.div_init) begin
         mode_sqrt_ff <= 1'b0;
         rad_ff       <= {root_ff, (blh_pkg::RAD_W-blh_pkg::ROOT_W)'(0)};
         rem_ff       <= '0;
         root_ff      <= '0;
         iter_ff      <= blh_pkg::ITER_FIRST;
      end else if (cmd.iter_en) begin
         rad_ff  <= mode_sqrt_ff ? rad_ff << 2 : rad_ff << 1;
         rem_ff  <= rem_sub;
         root_ff <= {root_ff[blh_pkg::ROOT_W-2:0], ge};
         iter_ff <= iter_ff - 1'b1;
      end
   end

   always_comb begin
      lim = (blh_pkg::WIDE_W'(bins_in_use) > blh_pkg::WIDE_W'(MAX_BINS)) ?
            blh_pkg::WIDE_W'(MAX_BINS) : blh_pkg::WIDE_W'(bins_in_use);
      status.iter_last  = iter_ff == '0;
      status.clear_last = clr_cnt_ff == BIN_AW'(MAX_BINS - 1);
      status.bond_ok    = (bin_width != '0) && (root_ff < blh_pkg::ROOT_W'(lim));
      q_addr            = root_ff[BIN_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_cnt_ff <= '0;
      else if (cmd.clear_step) clr_cnt_ff <= clr_cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) bin_mem[clr_cnt_ff] <= '0;
      else if (cmd.bin_wr) bin_mem[q_addr] <= bin_rd_ff + 32'd1;
      if (cmd.bin_rd) bin_rd_ff <= bin_mem[q_addr];
      else if (cmd.cnt_rd) bin_rd_ff <= bin_mem[rb_wide[BIN_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_status_ff <= 1'b0;
         res_hit_ff    <= '0;
         res_len_ff    <= '0;
         res_count_ff  <= '0;
      end else begin
         if (cmd.div_init) res_len_ff <= root_ff;
         if (cmd.check && !status.bond_ok) res_status_ff <= 1'b1;
         if (cmd.bin_wr) res_hit_ff <= root_ff[9:0];
         if (cmd.cnt_set) res_count_ff <= rb_ok_ff ? bin_rd_ff : '0;
      end
      if (cmd.push) begin
         rsp_status      <= res_status_ff;
         rsp_bin_hit     <= res_hit_ff;
         rsp_bond_length <= res_len_ff;
         rsp_bin_count   <= res_count_ff;
      end
   end

endmodule

`default_nettype wire
